// ===== hw/rtl/amix_pkg.sv =====
`timescale 1ns / 1ps
package amix_pkg;

  localparam int SRC_NUM    = 4;   // selector is two bits wide
  localparam int SRC_W      = 2;
  localparam int CNT_W      = 3;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = SMP_W + GAIN_W + 1;
  localparam int TERM_W     = SMP_W + 1;
  localparam int SUM_W      = SMP_W + 2;
  localparam int Q_SHIFT    = 15;
  localparam int Q_BIAS     = 32767;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 40;

  localparam logic [GAIN_W-1:0]      GAIN_UNITY = 16'h8000;
  localparam logic signed [SUM_W-1:0] SUM_MAX   = 18'sd32767;
  localparam logic signed [SUM_W-1:0] SUM_MIN   = -18'sd32768;
  localparam logic [SMP_W-1:0]       SMP_POS_SAT = 16'h7FFF;
  localparam logic [SMP_W-1:0]       SMP_NEG_SAT = 16'h8000;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_MIX   = 2'd1,
    CMD_END   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_SRC_COUNT = 3'd0,
    REG_GAIN_A    = 3'd1,
    REG_GAIN_B    = 3'd2,
    REG_GAIN_C    = 3'd3,
    REG_GAIN_D    = 3'd4,
    REG_RATE      = 3'd5,
    REG_MONO      = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    RATE_HOLD1  = 2'd0,
    RATE_HOLD2  = 2'd1,
    RATE_HOLD4  = 2'd2,
    RATE_HOLD4B = 2'd3
  } rate_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRC,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]               source_count;
    logic [SRC_NUM-1:0][GAIN_W-1:0] gain;
    logic [2*SRC_NUM-1:0]           rate_codes;
    logic [SRC_NUM-1:0]             mono_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    source_count: '0,
    gain:         {SRC_NUM{GAIN_UNITY}},
    rate_codes:   '0,
    mono_mask:    '0
  };

  typedef struct packed {
    logic load_in;
    logic do_write;
    logic do_end;
    logic src_rd;
    logic src_mul;
    logic src_acc;
    logic src_starve;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      no_sources;
    logic      src_last;
    logic      src_empty;
    logic      out_busy;
  } stat_t;

  function automatic logic [2:0] hold_len(input logic [1:0] code);
    logic [2:0] len;
    unique case (rate_code_t'(code))
      RATE_HOLD1:              len = 3'd1;
      RATE_HOLD2:              len = 3'd2;
      RATE_HOLD4, RATE_HOLD4B: len = 3'd4;
    endcase
    return len;
  endfunction

  // product / 32768, truncating toward zero
  function automatic logic signed [TERM_W-1:0] q15_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p[PROD_W-1] ? p + $signed(PROD_W'(Q_BIAS)) : p;
    return TERM_W'(adj >>> Q_SHIFT);
  endfunction

  function automatic logic [SMP_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic [SMP_W-1:0] r;
    priority if (v > SUM_MAX) r = SMP_POS_SAT;
    else if (v < SUM_MIN)     r = SMP_NEG_SAT;
    else                      r = v[SMP_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/amix_regs.sv =====
`timescale 1ns / 1ps
module amix_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [amix_pkg::CFG_AW-1:0]  paddr,
  input  logic [amix_pkg::CFG_DW-1:0]  pwdata,
  output logic [amix_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output amix_pkg::cfg_t               cfg
);
  import amix_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     gain_ok;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  // gains above unity are dropped
  assign gain_ok = (pwdata[GAIN_W-1:0] <= GAIN_UNITY);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SRC_COUNT: cfg_nxt.source_count = pwdata[CNT_W-1:0];
        REG_GAIN_A: if (gain_ok) cfg_nxt.gain[0] = pwdata[GAIN_W-1:0];
        REG_GAIN_B: if (gain_ok) cfg_nxt.gain[1] = pwdata[GAIN_W-1:0];
        REG_GAIN_C: if (gain_ok) cfg_nxt.gain[2] = pwdata[GAIN_W-1:0];
        REG_GAIN_D: if (gain_ok) cfg_nxt.gain[3] = pwdata[GAIN_W-1:0];
        REG_RATE:      cfg_nxt.rate_codes = pwdata[2*SRC_NUM-1:0];
        REG_MONO:      cfg_nxt.mono_mask  = pwdata[SRC_NUM-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_COUNT: prdata = CFG_DW'(cfg_r.source_count);
      REG_GAIN_A:    prdata = CFG_DW'(cfg_r.gain[0]);
      REG_GAIN_B:    prdata = CFG_DW'(cfg_r.gain[1]);
      REG_GAIN_C:    prdata = CFG_DW'(cfg_r.gain[2]);
      REG_GAIN_D:    prdata = CFG_DW'(cfg_r.gain[3]);
      REG_RATE:      prdata = CFG_DW'(cfg_r.rate_codes);
      REG_MONO:      prdata = CFG_DW'(cfg_r.mono_mask);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/amix_ctrl.sv =====
`timescale 1ns / 1ps
module amix_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  amix_pkg::stat_t stat,
  output amix_pkg::ctrl_t ctrl
);
  import amix_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.cmd == CMD_MIX && !stat.no_sources) state_nxt = ST_SRC;
        else                                          state_nxt = ST_DONE;
      end
      ST_SRC: begin
        if (!stat.src_empty)    state_nxt = ST_MUL;
        else if (stat.src_last) state_nxt = ST_DONE;
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = stat.src_last ? ST_DONE : ST_SRC;
      end
      ST_DONE: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.load_in = in_valid;
      end
      ST_DECODE: begin
        ctrl.do_write = (stat.cmd == CMD_WRITE);
        ctrl.do_end   = (stat.cmd == CMD_END);
      end
      ST_SRC: begin
        ctrl.src_rd     = !stat.src_empty;
        ctrl.src_starve = stat.src_empty;
      end
      ST_MUL:  ctrl.src_mul = 1'b1;
      ST_ACC:  ctrl.src_acc = 1'b1;
      ST_DONE: ctrl.emit    = !stat.out_busy;
      default: ;
    endcase
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted beat not decoded next cycle");

  a_mul_after_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> ($past(state_r) == ST_SRC))
    else $error("multiply without ring read");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> (state_r == ST_IDLE))
    else $error("controller not idle after result");

endmodule

// ===== hw/rtl/amix_dp.sv =====
`timescale 1ns / 1ps
module amix_dp #(
  parameter int RING_FRAMES = 16384,
  parameter int MAX_SOURCES = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  amix_pkg::cfg_t                    cfg,
  input  amix_pkg::ctrl_t                   ctrl,
  output amix_pkg::stat_t                   stat,
  input  logic [1:0]                        in_cmd,
  input  logic [amix_pkg::SRC_W-1:0]        in_sel,
  input  logic [amix_pkg::SMP_W-1:0]        in_left,
  input  logic [amix_pkg::SMP_W-1:0]        in_right,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [amix_pkg::OUT_DATA_W-1:0]   out_data
);
  import amix_pkg::*;

  localparam int SLOT_W     = $clog2(RING_FRAMES);
  localparam int IDX_W      = SLOT_W + 1;
  localparam int ADDR_W     = $clog2(MAX_SOURCES) + SLOT_W;
  localparam int RING_DEPTH = MAX_SOURCES * (2 ** SLOT_W);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(2 * RING_FRAMES - 1);
  localparam logic [IDX_W-1:0] RING_N   = IDX_W'(RING_FRAMES);
  localparam logic [IDX_W:0]   RING_2N  = (IDX_W + 1)'(2 * RING_FRAMES);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SOURCES);

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i < RING_N) ? i : i - RING_N;
    return r[SLOT_W-1:0];
  endfunction

  // latched command beat
  cmd_code_t          cmd_r;
  logic [SRC_W-1:0]   sel_r;
  logic [SMP_W-1:0]   left_r, right_r;

  // per-source state
  logic [IDX_W-1:0]   wr_idx_r  [SRC_NUM];
  logic [IDX_W-1:0]   wr_idx_nxt[SRC_NUM];
  logic [IDX_W-1:0]   mix_idx_r  [SRC_NUM];
  logic [IDX_W-1:0]   mix_idx_nxt[SRC_NUM];
  logic [1:0]         hold_r  [SRC_NUM];
  logic [1:0]         hold_nxt[SRC_NUM];
  logic [SRC_NUM-1:0] starve_r, starve_nxt;
  logic [SRC_NUM-1:0] end_r, end_nxt;

  // mix walk and result
  logic [SRC_W-1:0]        src_r, src_nxt;
  logic signed [SUM_W-1:0] sum_l_r, sum_l_nxt, sum_r_r, sum_r_nxt;
  logic                    acc_r, acc_nxt;
  logic [SRC_NUM-1:0]      under_r, under_nxt;
  logic                    done_r, done_nxt;

  logic [2*SMP_W-1:0]       ring_mem [RING_DEPTH];
  logic [2*SMP_W-1:0]       rd_data_r;
  logic signed [PROD_W-1:0] prod_l_r, prod_r_r;

  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  logic [CNT_W-1:0]         act_cnt;
  logic                     sel_ok, not_full, write_ok;
  logic [IDX_W:0]           used_diff, used;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic [2*SMP_W-1:0]       wr_word;
  logic signed [SMP_W-1:0]  smp_l, smp_r;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [TERM_W-1:0] term_l, term_r;
  logic [2:0]               hp_inc, hp_len;
  logic                     hold_wrap;
  logic [IDX_W-1:0]         mix_new;
  logic [1:0]               hold_new;

  assign act_cnt = (cfg.source_count > MAX_CNT) ? MAX_CNT : cfg.source_count;

  // write side: occupancy counted against the mix pointer
  assign sel_ok    = ({1'b0, sel_r} < act_cnt);
  assign used_diff = {1'b0, wr_idx_r[sel_r]} - {1'b0, mix_idx_r[sel_r]};
  assign used      = used_diff[IDX_W] ? used_diff + RING_2N : used_diff;
  assign not_full  = (used < {1'b0, RING_N});
  assign write_ok  = ctrl.do_write && sel_ok && !end_r[sel_r] && not_full;
  assign wr_word   = {cfg.mono_mask[sel_r] ? left_r : right_r, left_r};
  assign wr_addr   = ADDR_W'({sel_r, slot_of(wr_idx_r[sel_r])});
  assign rd_addr   = ADDR_W'({src_r, slot_of(mix_idx_r[src_r])});

  always_ff @(posedge clk) begin
    if (write_ok) ring_mem[wr_addr] <= wr_word;
    if (ctrl.src_rd) rd_data_r <= ring_mem[rd_addr];
  end

  // scale stage
  assign smp_l  = rd_data_r[SMP_W-1:0];
  assign smp_r  = rd_data_r[2*SMP_W-1:SMP_W];
  assign gain_s = {1'b0, cfg.gain[src_r]};

  always_ff @(posedge clk) begin
    if (ctrl.src_mul) begin
      prod_l_r <= smp_l * gain_s;
      prod_r_r <= smp_r * gain_s;
    end
  end

  assign term_l    = q15_trunc(prod_l_r);
  assign term_r    = q15_trunc(prod_r_r);
  assign hp_inc    = {1'b0, hold_r[src_r]} + 3'd1;
  assign hp_len    = hold_len(cfg.rate_codes[{src_r, 1'b0} +: 2]);
  assign hold_wrap = (hp_inc >= hp_len);
  assign mix_new   = hold_wrap ? idx_next(mix_idx_r[src_r]) : mix_idx_r[src_r];
  assign hold_new  = hold_wrap ? 2'd0 : hp_inc[1:0];

  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    mix_idx_nxt = mix_idx_r;
    hold_nxt    = hold_r;
    starve_nxt  = starve_r;
    end_nxt     = end_r;
    src_nxt     = src_r;
    sum_l_nxt   = sum_l_r;
    sum_r_nxt   = sum_r_r;
    acc_nxt     = acc_r;
    under_nxt   = under_r;
    done_nxt    = done_r;

    if (ctrl.load_in) begin
      src_nxt   = '0;
      sum_l_nxt = '0;
      sum_r_nxt = '0;
      acc_nxt   = 1'b0;
      under_nxt = '0;
      done_nxt  = (cmd_code_t'(in_cmd) == CMD_MIX);
    end

    if (write_ok) begin
      wr_idx_nxt[sel_r] = idx_next(wr_idx_r[sel_r]);
      acc_nxt           = 1'b1;
    end

    if (ctrl.do_end && sel_ok) end_nxt[sel_r] = 1'b1;

    if (ctrl.src_starve) begin
      if (!end_r[src_r] && !starve_r[src_r]) begin
        starve_nxt[src_r] = 1'b1;
        under_nxt[src_r]  = 1'b1;
      end
      if (!end_r[src_r] || hold_r[src_r] != 2'd0) done_nxt = 1'b0;
      src_nxt = src_r + 1'b1;
    end

    if (ctrl.src_acc) begin
      starve_nxt[src_r]  = 1'b0;
      sum_l_nxt          = sum_l_r + SUM_W'(term_l);
      sum_r_nxt          = sum_r_r + SUM_W'(term_r);
      mix_idx_nxt[src_r] = mix_new;
      hold_nxt[src_r]    = hold_new;
      if (!end_r[src_r] || mix_new != wr_idx_r[src_r] || hold_new != 2'd0) done_nxt = 1'b0;
      src_nxt = src_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SRC_NUM; i++) begin
        wr_idx_r[i]  <= '0;
        mix_idx_r[i] <= '0;
        hold_r[i]    <= '0;
      end
      starve_r <= '0;
      end_r    <= '0;
      src_r    <= '0;
      cmd_r    <= CMD_NOP;
      acc_r    <= 1'b0;
      under_r  <= '0;
      done_r   <= 1'b0;
      sum_l_r  <= '0;
      sum_r_r  <= '0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      mix_idx_r <= mix_idx_nxt;
      hold_r    <= hold_nxt;
      starve_r  <= starve_nxt;
      end_r     <= end_nxt;
      src_r     <= src_nxt;
      acc_r     <= acc_nxt;
      under_r   <= under_nxt;
      done_r    <= done_nxt;
      sum_l_r   <= sum_l_nxt;
      sum_r_r   <= sum_r_nxt;
      if (ctrl.load_in) cmd_r <= cmd_code_t'(in_cmd);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      sel_r   <= in_sel;
      left_r  <= in_left;
      right_r <= in_right;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_data_r <= {2'b00, done_r, under_r, acc_r, sat16(sum_r_r), sat16(sum_l_r)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.cmd        = cmd_r;
  assign stat.no_sources = (act_cnt == '0);
  assign stat.src_last   = (({1'b0, src_r} + CNT_W'(1)) == act_cnt);
  assign stat.src_empty  = (mix_idx_r[src_r] == wr_idx_r[src_r]);
  assign stat.out_busy   = out_valid_r && !out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten while waiting");

  a_mul_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.src_mul |-> $past(ctrl.src_rd))
    else $error("multiply on stale ring data");

  a_rd_active_src: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.src_rd |-> ({1'b0, src_r} < act_cnt))
    else $error("ring read for inactive source");

endmodule

// ===== hw/rtl/four_source_audio_mixer_core.sv =====
`timescale 1ns / 1ps
// Sequence: write, end and unused command beats pass through the decode and done states;
// a mix beat also walks each active source: ring read, multiply and accumulate if it holds data, else a skip.
// Flow: one beat in flight; the next beat is taken once the result register has been loaded and the
// sequencer is back in idle; the done state waits while the result register is still full.
// Reset: synchronous, active low; ring pointers, flags, sums, config and out valid cleared, ring and data not cleared.
module four_source_audio_mixer_core #(
  parameter int RING_FRAMES = 16384,
  parameter int MAX_SOURCES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [amix_pkg::IN_DATA_W-1:0]       in_tdata,   // in_left[15:0], in_right[31:16]
  input  logic [amix_pkg::IN_USER_W-1:0]       in_tuser,   // command[1:0], source_sel[3:2]
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [amix_pkg::OUT_DATA_W-1:0]      out_tdata,  // out_left[15:0], out_right[31:16],
                                                           // accepted[32], underrun_mask[36:33],
                                                           // drained[37], zero[39:38]
  // register port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [amix_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [amix_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [amix_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready
);
  import amix_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  // Register file: source count, four Q15 gains, rate codes and mono mask at 4-byte
  // spacing. Gain writes above unity are discarded; pready is tied high.
  amix_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Sequencer: takes a beat when idle, decodes it, then for a mix walks the active
  // sources one by one (ring read, scale, accumulate) and parks until the result
  // register is free.
  amix_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Datapath: per-source rings in one memory, write/mix pointers modulo twice the ring
  // length (full and empty stay distinct), shared pair of Q15 multipliers, 18-bit
  // accumulators saturated to 16 bits on the way into the result register.
  amix_dp #(
    .RING_FRAMES (RING_FRAMES),
    .MAX_SOURCES (MAX_SOURCES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_cmd    (in_tuser[1:0]),
    .in_sel    (in_tuser[3:2]),
    .in_left   (in_tdata[SMP_W-1:0]),
    .in_right  (in_tdata[2*SMP_W-1:SMP_W]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule
